// ===== sv/tscb_pkg.sv =====
// Shared constants, command codes and controller/datapath types for the text screen buffer.
package tscb_pkg;

   localparam int CELLS      = 4096;
   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 128;

   localparam int ADDR_W     = $clog2(CELLS);
   localparam int AREA_W     = ADDR_W + 1;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);

   localparam int CMD_W      = 4;
   localparam int HEIGHT_W   = 6;
   localparam int WIDTH_W    = 8;
   localparam int TROW_W     = 6;
   localparam int TCOL_W     = 8;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [HEIGHT_W-1:0]  HEIGHT_RST = HEIGHT_W'(24);
   localparam logic [WIDTH_W-1:0]   WIDTH_RST  = WIDTH_W'(80);
   localparam logic [CHAR_W-1:0]    NUL_CHAR   = CHAR_W'(0);

   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = CSR_IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_MOVE    = 4'd0,
      CMD_HOME    = 4'd1,
      CMD_FORWARD = 4'd2,
      CMD_BACK    = 4'd3,
      CMD_UP      = 4'd4,
      CMD_DOWN    = 4'd5,
      CMD_END     = 4'd6,
      CMD_PUT     = 4'd7,
      CMD_GET     = 4'd8,
      CMD_CLEAR   = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic exec;
      logic clr_step;
      logic rd_en;
      logic load_rsp;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_clear;
      logic clr_last;
      logic rsp_full;
   } sts_type;

endpackage

// ===== sv/tscb_ctrl.sv =====
// Sequencing state machine for the text screen buffer.
module tscb_ctrl import tscb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      rsp_free;

   assign rsp_free = !sts.rsp_full || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.is_clear ? ST_CLEAR : ST_READ;
         end
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
         end
         ST_READ: begin
            ctl.rd_en = 1'b1;
         end
         ST_DONE: begin
            ctl.load_rsp = rsp_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

// ===== sv/tscb_datapath.sv =====
// Cursor registers, cell memory, screen size registers and result register.
module tscb_datapath import tscb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [TROW_W-1:0]     req_target_row,
   input  logic [TCOL_W-1:0]     req_target_col,
   input  logic [CHAR_W-1:0]     req_char_in,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_char_out,
   output logic [HEIGHT_W-1:0]   rsp_cursor_row,
   output logic [WIDTH_W-1:0]    rsp_cursor_col,
   output logic                  rsp_bell,
   output logic                  rsp_range_error,
   output logic                  rsp_null_ignored,
   input  ctl_type               ctl,
   output sts_type               sts
);

   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;

   cmd_type             cmd_ff;
   logic [TROW_W-1:0]   trow_ff;
   logic [TCOL_W-1:0]   tcol_ff;
   logic [CHAR_W-1:0]   char_ff;

   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;

   logic                bell_ff, bell_in;
   logic                rerr_ff, rerr_in;
   logic                nul_ff, nul_in;

   logic [CHAR_W-1:0]   mem [CELLS];
   logic [CHAR_W-1:0]   rd_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [HEIGHT_W-1:0] rsp_row_ff;
   logic [WIDTH_W-1:0]  rsp_col_ff;
   logic                rsp_bell_ff, rsp_rerr_ff, rsp_nul_ff;

   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic [AREA_W-1:0]   area;
   logic [ADDR_W-1:0]   area_m1;
   logic [COL_W-1:0]    w_m1;
   logic [ROW_W-1:0]    h_m1;
   logic                in_range;
   logic [ROW_W-1:0]    mv_row;
   logic [COL_W-1:0]    mv_col;
   logic [ADDR_W-1:0]   mv_idx;
   logic [AREA_W-1:0]   fwd_idx;
   logic                csr_wr;

   // ---- screen size, saturated into the legal range
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_COLS)) begin
         eff_w = WIDTH_W'(MAX_COLS);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_ROWS)) begin
         eff_h = HEIGHT_W'(MAX_ROWS);
      end else begin
         eff_h = height_ff;
      end
   end

   assign area    = AREA_W'(eff_w) * AREA_W'(eff_h);
   assign area_m1 = ADDR_W'(area - AREA_W'(1));
   assign w_m1    = COL_W'(eff_w - WIDTH_W'(1));
   assign h_m1    = ROW_W'(eff_h - HEIGHT_W'(1));

   // ---- configuration
   assign csr_wr = csr_valid && csr_ready;

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      if (csr_wr && csr_index == CSR_HEIGHT) height_in = HEIGHT_W'(csr_data);
      if (csr_wr && csr_index == CSR_WIDTH)  width_in  = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RST;
         width_ff  <= WIDTH_RST;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
      end
   end

   // ---- request word
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff  <= cmd_type'(req_command);
         trow_ff <= req_target_row;
         tcol_ff <= req_target_col;
         char_ff <= req_char_in;
      end
   end

   // ---- cursor update
   assign in_range = (trow_ff != '0) && (trow_ff <= eff_h) &&
                     (tcol_ff != '0) && (tcol_ff <= eff_w);
   assign mv_row   = ROW_W'(trow_ff - TROW_W'(1));
   assign mv_col   = COL_W'(tcol_ff - TCOL_W'(1));
   assign mv_idx   = ADDR_W'(AREA_W'(mv_row) * AREA_W'(eff_w) + AREA_W'(mv_col));
   assign fwd_idx  = AREA_W'(idx_ff) + AREA_W'(1);

   always_comb begin
      idx_in  = idx_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      bell_in = bell_ff;
      rerr_in = rerr_ff;
      nul_in  = nul_ff;
      if (csr_wr && (csr_index == CSR_HEIGHT || csr_index == CSR_WIDTH)) begin
         // a write to the height or width register homes the cursor
         idx_in = '0;
         row_in = '0;
         col_in = '0;
      end else if (ctl.exec) begin
         bell_in = 1'b0;
         rerr_in = 1'b0;
         nul_in  = 1'b0;
         unique case (cmd_ff)
            CMD_MOVE, CMD_GET: begin
               if (in_range) begin
                  idx_in = mv_idx;
                  row_in = mv_row;
                  col_in = mv_col;
               end else begin
                  rerr_in = 1'b1;
               end
            end
            CMD_HOME, CMD_CLEAR: begin
               idx_in = '0;
               row_in = '0;
               col_in = '0;
            end
            CMD_FORWARD: begin
               if (fwd_idx >= area) begin
                  idx_in = '0;
                  row_in = '0;
                  col_in = '0;
               end else begin
                  idx_in = ADDR_W'(fwd_idx);
                  if (col_ff == w_m1) begin
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            end
            CMD_BACK: begin
               if (idx_ff == '0) begin
                  idx_in = area_m1;
                  row_in = h_m1;
                  col_in = w_m1;
               end else begin
                  idx_in = idx_ff - ADDR_W'(1);
                  if (col_ff == '0) begin
                     col_in = w_m1;
                     row_in = row_ff - ROW_W'(1);
                  end else begin
                     col_in = col_ff - COL_W'(1);
                  end
               end
            end
            CMD_UP: begin
               if (row_ff == '0) begin
                  bell_in = 1'b1;
               end else begin
                  row_in = row_ff - ROW_W'(1);
                  idx_in = idx_ff - ADDR_W'(eff_w);
               end
            end
            CMD_DOWN: begin
               if (HEIGHT_W'(row_ff) + HEIGHT_W'(1) >= eff_h) begin
                  bell_in = 1'b1;
               end else begin
                  row_in = row_ff + ROW_W'(1);
                  idx_in = ADDR_W'(AREA_W'(idx_ff) + AREA_W'(eff_w));
               end
            end
            CMD_END: begin
               idx_in = area_m1;
               row_in = h_m1;
               col_in = w_m1;
            end
            CMD_PUT: begin
               nul_in = (char_ff == NUL_CHAR);
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      bell_ff <= bell_in;
      rerr_ff <= rerr_in;
      nul_ff  <= nul_in;
   end

   // ---- clear sweep counter
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (ctl.exec) begin
         clr_cnt_in = '0;
      end else if (ctl.clr_step) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---- cell memory, one port
   assign mem_addr = ctl.clr_step ? clr_cnt_ff : idx_ff;
   assign mem_we   = ctl.clr_step ||
                     (ctl.exec && cmd_ff == CMD_PUT && char_ff != NUL_CHAR);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= char_ff;
      if (ctl.rd_en) rd_ff <= mem[mem_addr];
   end

   // ---- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_char_ff <= rd_ff;
         rsp_row_ff  <= HEIGHT_W'(row_ff) + HEIGHT_W'(1);
         rsp_col_ff  <= WIDTH_W'(col_ff) + WIDTH_W'(1);
         rsp_bell_ff <= bell_ff;
         rsp_rerr_ff <= rerr_ff;
         rsp_nul_ff  <= nul_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_bell         = rsp_bell_ff;
   assign rsp_range_error  = rsp_rerr_ff;
   assign rsp_null_ignored = rsp_nul_ff;

   assign sts.is_clear = (cmd_ff == CMD_CLEAR);
   assign sts.clr_last = (clr_cnt_ff == ADDR_W'(CELLS - 1));
   assign sts.rsp_full = rsp_valid_ff;

   // ---- checks
   // linear index always agrees with row/column under the current width
   a_idx_matches: assert property (@(posedge clock) disable iff (reset)
      idx_ff == ADDR_W'(AREA_W'(row_ff) * AREA_W'(eff_w) + AREA_W'(col_ff)))
      else $error("cursor index disagrees with row/column");

   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_m1 && col_ff <= w_m1)
      else $error("cursor outside the screen");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   a_sweep_only_on_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clr_step |-> sts.is_clear)
      else $error("clear sweep without a clear command");

endmodule

// ===== sv/text_screen_cursor_buffer.sv =====
// Top level of the text screen buffer: controller plus datapath.
//
// Usage:
//   Request channel (req_*): one command word per handshake, with target row/column
//   (one-based) and a character. Result channel (rsp_*): one word per command, giving
//   the character under the cursor and the one-based cursor position after the
//   command, plus bell, range_error and null_ignored flags.
//   Config channel (csr_*): index 0 writes screen height, index 1 screen width; a
//   write to either homes the cursor. csr_ready is always high; write only while idle.
// Sequence:
//   A word is accepted in the idle state; the block then steps through exec, read
//   (or clear, then read) and done, loads the result once the output register is
//   free and returns to idle to accept the next word. The cell memory has one port:
//   the write of a put happens in the exec state, the read of the cell under the
//   cursor in the read state. Clear sweeps all 4096 cells, one per cycle.
// Reset: 24 rows by 80 columns, cursor at row 1 column 1, result channel empty.
//   Cell contents are undefined until a clear or put writes them.
// Stall: a result that is not taken holds in the output register; the block still
//   runs the next command and waits before loading its result.
module text_screen_cursor_buffer import tscb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [TROW_W-1:0]     req_target_row,
   input  logic [TCOL_W-1:0]     req_target_col,
   input  logic [CHAR_W-1:0]     req_char_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_char_out,
   output logic [HEIGHT_W-1:0]   rsp_cursor_row,
   output logic [WIDTH_W-1:0]    rsp_cursor_col,
   output logic                  rsp_bell,
   output logic                  rsp_range_error,
   output logic                  rsp_null_ignored,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   tscb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tscb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_target_row   (req_target_row),
      .req_target_col   (req_target_col),
      .req_char_in      (req_char_in),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_bell         (rsp_bell),
      .rsp_range_error  (rsp_range_error),
      .rsp_null_ignored (rsp_null_ignored),
      .ctl              (ctl),
      .sts              (sts)
   );

endmodule
